>>> rtl/tdq_pkg.sv
package tdq_pkg;

   localparam int FRAC_BITS = 15;

   // event kinds carried on req_tuser
   localparam logic [1:0] EV_PRESS   = 2'd0;
   localparam logic [1:0] EV_MOVE    = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   // csr register indexes
   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   localparam logic [15:0] RADIUS_RESET = 16'd256;
   localparam logic [15:0] THRESH_RESET = 16'd66;

   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   // clamp to the Q1.15 range
   function automatic logic signed [15:0] sat_q(input logic signed [55:0] v);
      logic signed [15:0] r;
      if (v < -56'sd32768) begin
         r = 16'sh8000;
      end else if (v > 56'sd32767) begin
         r = 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // divide by 2^15, rounding half away from zero
   function automatic logic signed [55:0] rnd_q(input logic signed [55:0] v);
      logic [55:0] mag;
      logic [55:0] q;
      mag = v[55] ? 56'(-v) : 56'(v);
      q   = (mag + 56'd16384) >> FRAC_BITS;
      return v[55] ? -$signed(q) : $signed(q);
   endfunction

endpackage

>>> rtl/tdq_mul.sv
module tdq_mul (
   input  logic               clock,
   input  logic signed [27:0] mul_a,
   input  logic signed [27:0] mul_b,
   output logic signed [55:0] mul_p
);
   logic signed [55:0] p_ff;
   logic signed [55:0] p_in;

   assign p_in  = mul_a * mul_b;
   assign mul_p = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule

>>> rtl/tdq_div.sv
module tdq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tdq_pkg::div_req_type div_req,
   output logic                 div_done,
   output logic [17:0]          div_quo
);
   import tdq_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [17:0] nlo_ff, nlo_in;
   logic [31:0] den_ff, den_in;
   logic [17:0] quo_ff, quo_in;
   logic [32:0] trial;

   // quotient is known to stay below 2^18, so the top bits preload the remainder
   assign trial = {rem_ff, nlo_ff[17]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      nlo_in  = nlo_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd17;
         rem_in  = {2'd0, div_req.num[47:18]};
         nlo_in  = div_req.num[17:0];
         den_in  = div_req.den;
      end else if (busy_ff) begin
         nlo_in = {nlo_ff[16:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[16:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[16:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nlo_ff <= nlo_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;
endmodule

>>> rtl/tdq_sqrt.sv
module tdq_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  tdq_pkg::sqrt_req_type sq_req,
   output logic                  sq_done,
   output logic [31:0]           sq_root
);
   import tdq_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (sq_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         v_in    = sq_req.radicand;
         res_in  = 64'd0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         // one result bit per cycle
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sq_done = done_ff;
   assign sq_root = res_ff[31:0];
endmodule

>>> rtl/trackball_drag_to_quaternion.sv
// Virtual trackball: pointer events in, rotation quaternions out.
// req channel: one pointer event per transaction, kind on req_tuser
// (press, move, release), button, position and viewport size on req_tdata.
// rsp channel: exactly one result transaction per event, carrying the
// handled flag, the Q1.15 quaternion (w, x, y, z), the viewport error flag
// and rotation_valid on rsp_tuser.
// csr port: sphere_radius (index 0, Q8.8) and move_threshold (index 1,
// Q0.16), written whenever csr_we is high; write them while idle.
// A release, an unknown kind or an event without the left button goes
// straight from idle to the result state. A press or a move runs
// through the serial square root unit and the serial divider, shared by
// all steps; a move that rotates also takes a one-bit-per-cycle
// normalizing shift of the cross product.
// One event at a time: req_tready is high only while the block is idle.
// The result waits in its register while rsp_tready is low.
// Reset (synchronous) restores the registers to 256 and 66, the stored
// point to (0, 0, 1.0) and the stored viewport to zero.
module trackball_drag_to_quaternion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_button, pointer_x, pointer_y, view_width, view_height
   input  logic [55:0] req_tdata,
   // req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // handled, quat_w, quat_x, quat_y, quat_z, view_error
   output logic [71:0] rsp_tdata,
   // rotation_valid
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tdq_pkg::*;

   localparam logic [5:0] ST_IDLE = 6'd0;
   localparam logic [5:0] ST_SQX  = 6'd1;
   localparam logic [5:0] ST_SQY  = 6'd2;
   localparam logic [5:0] ST_BR   = 6'd3;
   localparam logic [5:0] ST_BRSQ = 6'd4;
   localparam logic [5:0] ST_CLS  = 6'd5;
   localparam logic [5:0] ST_LEN  = 6'd6;
   localparam logic [5:0] ST_PDX  = 6'd7;
   localparam logic [5:0] ST_PDY  = 6'd8;
   localparam logic [5:0] ST_PZ1  = 6'd9;
   localparam logic [5:0] ST_PZ2  = 6'd10;
   localparam logic [5:0] ST_PZ3  = 6'd11;
   localparam logic [5:0] ST_PEND = 6'd12;
   localparam logic [5:0] ST_T1   = 6'd13;
   localparam logic [5:0] ST_T2   = 6'd14;
   localparam logic [5:0] ST_T3   = 6'd15;
   localparam logic [5:0] ST_T4   = 6'd16;
   localparam logic [5:0] ST_D1   = 6'd17;
   localparam logic [5:0] ST_D2   = 6'd18;
   localparam logic [5:0] ST_D3   = 6'd19;
   localparam logic [5:0] ST_COS  = 6'd20;
   localparam logic [5:0] ST_SIN1 = 6'd21;
   localparam logic [5:0] ST_SIN2 = 6'd22;
   localparam logic [5:0] ST_C0A  = 6'd23;
   localparam logic [5:0] ST_C0B  = 6'd24;
   localparam logic [5:0] ST_C1A  = 6'd25;
   localparam logic [5:0] ST_C1B  = 6'd26;
   localparam logic [5:0] ST_C2A  = 6'd27;
   localparam logic [5:0] ST_C2B  = 6'd28;
   localparam logic [5:0] ST_MAG  = 6'd29;
   localparam logic [5:0] ST_NORM = 6'd30;
   localparam logic [5:0] ST_SUM1 = 6'd31;
   localparam logic [5:0] ST_SUM2 = 6'd32;
   localparam logic [5:0] ST_SUM3 = 6'd33;
   localparam logic [5:0] ST_AXL  = 6'd34;
   localparam logic [5:0] ST_AX   = 6'd35;
   localparam logic [5:0] ST_AXM  = 6'd36;
   localparam logic [5:0] ST_AXQ  = 6'd37;
   localparam logic [5:0] ST_OUT  = 6'd38;

   logic [5:0]         state_ff, state_in;
   logic [15:0]        radius_ff, radius_in;
   logic [15:0]        thresh_ff, thresh_in;
   logic [12:0]        stw_ff, stw_in;
   logic [12:0]        sth_ff, sth_in;
   logic signed [15:0] lx_ff, lx_in, ly_ff, ly_in, lz_ff, lz_in;
   logic signed [15:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic               move_ff, move_in;
   logic               inside_ff, inside_in;
   logic signed [13:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [11:0]        base_ff, base_in;
   logic [25:0]        s_ff, s_in;
   logic [26:0]        br_ff, br_in;
   logic [31:0]        len_ff, len_in;
   logic signed [55:0] acc_ff, acc_in;
   logic signed [16:0] cos_ff, cos_in;
   logic [15:0]        sin_ff, sin_in;
   logic [31:0]        m_ff [3];
   logic [31:0]        m_in [3];
   logic [2:0]         cneg_ff, cneg_in;
   logic [31:0]        mx_ff, mx_in;
   logic signed [18:0] ax_ff, ax_in;
   logic [1:0]         k_ff, k_in;
   logic               hnd_ff, hnd_in;
   logic               rv_ff, rv_in;
   logic               verr_ff, verr_in;
   logic signed [15:0] qw_ff, qw_in;
   logic signed [15:0] qv_ff [3];
   logic signed [15:0] qv_in [3];

   logic signed [27:0] mul_a, mul_b;
   logic signed [55:0] mul_p;
   div_req_type        div_req;
   logic               div_done;
   logic [17:0]        div_quo;
   sqrt_req_type       sq_req;
   logic               sq_done;
   logic [31:0]        sq_root;

   logic [1:0]         in_kind;
   logic               in_left;
   logic [11:0]        in_px, in_py;
   logic [12:0]        use_w, use_h;
   logic [11:0]        cx, cy;
   logic [12:0]        mag_dx, mag_dy;
   logic [15:0]        radius_eff;
   logic signed [16:0] ex, ey, ez;
   logic signed [55:0] dq;
   logic signed [55:0] cdiff;
   logic [31:0]        cmag;
   logic signed [55:0] rnd_dot;
   logic signed [55:0] pz_rem;
   logic [31:0]        mx3;

   tdq_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   tdq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   tdq_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .sq_req  (sq_req),
      .sq_done (sq_done),
      .sq_root (sq_root)
   );

   assign in_kind    = req_tuser;
   assign in_left    = req_tdata[0];
   assign in_px      = req_tdata[12:1];
   assign in_py      = req_tdata[24:13];
   assign use_w      = (in_kind == EV_PRESS) ? req_tdata[37:25] : stw_ff;
   assign use_h      = (in_kind == EV_PRESS) ? req_tdata[50:38] : sth_ff;
   assign cx         = use_w[12:1];
   assign cy         = use_h[12:1];
   assign mag_dx     = dx_ff[13] ? 13'(-dx_ff) : 13'(dx_ff);
   assign mag_dy     = dy_ff[13] ? 13'(-dy_ff) : 13'(dy_ff);
   assign radius_eff = (radius_ff == 16'd0) ? 16'd1 : radius_ff;
   assign ex         = 17'(lx_ff) - 17'(bx_ff);
   assign ey         = 17'(ly_ff) - 17'(by_ff);
   assign ez         = 17'(lz_ff) - 17'(bz_ff);
   assign dq         = $signed({38'd0, div_quo});
   assign cdiff      = acc_ff - mul_p;
   assign cmag       = cdiff[55] ? 32'(-cdiff) : 32'(cdiff);
   assign rnd_dot    = rnd_q(acc_ff + mul_p);
   assign pz_rem     = acc_ff - mul_p;
   assign mx3        = (m_ff[0] > m_ff[1]) ?
                       ((m_ff[0] > m_ff[2]) ? m_ff[0] : m_ff[2]) :
                       ((m_ff[1] > m_ff[2]) ? m_ff[1] : m_ff[2]);

   always_comb begin
      state_in  = state_ff;
      stw_in    = stw_ff;
      sth_in    = sth_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      lz_in     = lz_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      bz_in     = bz_ff;
      move_in   = move_ff;
      inside_in = inside_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      base_in   = base_ff;
      s_in      = s_ff;
      br_in     = br_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      cos_in    = cos_ff;
      sin_in    = sin_ff;
      m_in      = m_ff;
      cneg_in   = cneg_ff;
      mx_in     = mx_ff;
      ax_in     = ax_ff;
      k_in      = k_ff;
      hnd_in    = hnd_ff;
      rv_in     = rv_ff;
      verr_in   = verr_ff;
      qw_in     = qw_ff;
      qv_in     = qv_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      sq_req    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hnd_in  = 1'b0;
               rv_in   = 1'b0;
               verr_in = 1'b0;
               qw_in   = '0;
               qv_in   = '{default: '0};
               state_in = ST_OUT;
               if (in_kind == EV_RELEASE) begin
                  hnd_in = 1'b1;
               end else if ((in_kind == EV_PRESS || in_kind == EV_MOVE) && in_left) begin
                  hnd_in = 1'b1;
                  if (in_kind == EV_PRESS) begin
                     stw_in = req_tdata[37:25];
                     sth_in = req_tdata[50:38];
                  end
                  dx_in    = $signed({2'd0, in_px}) - $signed({2'd0, cx});
                  dy_in    = $signed({2'd0, in_py}) - $signed({2'd0, cy});
                  base_in  = (cx < cy) ? cx : cy;
                  verr_in  = ((cx < cy) ? cx : cy) == 12'd0;
                  move_in  = (in_kind == EV_MOVE);
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            mul_a    = 28'(dx_ff);
            mul_b    = 28'(dx_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            s_in     = 26'(mul_p);
            mul_a    = 28'(dy_ff);
            mul_b    = 28'(dy_ff);
            state_in = ST_BR;
         end
         ST_BR: begin
            s_in     = 26'(56'(s_ff) + mul_p);
            mul_a    = $signed({16'd0, base_ff});
            mul_b    = $signed({12'd0, radius_eff});
            state_in = ST_BRSQ;
         end
         ST_BRSQ: begin
            br_in    = 27'(mul_p);
            mul_a    = mul_p[27:0];
            mul_b    = mul_p[27:0];
            state_in = ST_CLS;
         end
         ST_CLS: begin
            if (base_ff != 12'd0 && {14'd0, s_ff, 16'd0} < 56'(mul_p)) begin
               inside_in       = 1'b1;
               div_req.start   = 1'b1;
               div_req.num     = (48'(mag_dx) << 23) + 48'(br_ff[26:1]);
               div_req.den     = 32'(br_ff);
               state_in        = ST_PDX;
            end else if (s_ff == 26'd0) begin
               inside_in = 1'b0;
               bx_in     = '0;
               by_in     = '0;
               bz_in     = 16'sh7fff;
               state_in  = ST_PEND;
            end else begin
               inside_in       = 1'b0;
               sq_req.start    = 1'b1;
               sq_req.radicand = {s_ff, 38'd0};
               state_in        = ST_LEN;
            end
         end
         ST_LEN: begin
            if (sq_done) begin
               len_in        = sq_root;
               div_req.start = 1'b1;
               div_req.num   = (48'(mag_dx) << 34) + 48'(sq_root[31:1]);
               div_req.den   = sq_root;
               state_in      = ST_PDX;
            end
         end
         ST_PDX: begin
            if (div_done) begin
               bx_in         = sat_q(dx_ff[13] ? -dq : dq);
               div_req.start = 1'b1;
               if (inside_ff) begin
                  div_req.num = (48'(mag_dy) << 23) + 48'(br_ff[26:1]);
                  div_req.den = 32'(br_ff);
               end else begin
                  div_req.num = (48'(mag_dy) << 34) + 48'(len_ff[31:1]);
                  div_req.den = len_ff;
               end
               state_in = ST_PDY;
            end
         end
         ST_PDY: begin
            if (div_done) begin
               by_in = sat_q(dy_ff[13] ? -dq : dq);
               if (inside_ff) begin
                  mul_a    = 28'(bx_ff);
                  mul_b    = 28'(bx_ff);
                  state_in = ST_PZ1;
               end else begin
                  bz_in    = '0;
                  state_in = ST_PEND;
               end
            end
         end
         ST_PZ1: begin
            acc_in   = 56'sd1073741824 - mul_p;
            mul_a    = 28'(by_ff);
            mul_b    = 28'(by_ff);
            state_in = ST_PZ2;
         end
         ST_PZ2: begin
            sq_req.start    = 1'b1;
            sq_req.radicand = (pz_rem > 56'sd0) ? 64'(pz_rem) : 64'd0;
            state_in        = ST_PZ3;
         end
         ST_PZ3: begin
            if (sq_done) begin
               bz_in    = sat_q($signed({24'd0, sq_root}));
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (!move_ff) begin
               lx_in    = bx_ff;
               ly_in    = by_ff;
               lz_in    = bz_ff;
               state_in = ST_OUT;
            end else begin
               mul_a    = 28'(ex);
               mul_b    = 28'(ex);
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            acc_in   = mul_p;
            mul_a    = 28'(ey);
            mul_b    = 28'(ey);
            state_in = ST_T2;
         end
         ST_T2: begin
            acc_in   = acc_ff + mul_p;
            mul_a    = 28'(ez);
            mul_b    = 28'(ez);
            state_in = ST_T3;
         end
         ST_T3: begin
            acc_in   = acc_ff + mul_p;
            mul_a    = $signed({12'd0, thresh_ff});
            mul_b    = $signed({12'd0, thresh_ff});
            state_in = ST_T4;
         end
         ST_T4: begin
            if ((acc_ff <<< 2) < mul_p) begin
               // too small a move: keep the point, no rotation
               lx_in    = bx_ff;
               ly_in    = by_ff;
               lz_in    = bz_ff;
               state_in = ST_OUT;
            end else begin
               mul_a    = 28'(lx_ff);
               mul_b    = 28'(bx_ff);
               state_in = ST_D1;
            end
         end
         ST_D1: begin
            acc_in   = mul_p;
            mul_a    = 28'(ly_ff);
            mul_b    = 28'(by_ff);
            state_in = ST_D2;
         end
         ST_D2: begin
            acc_in   = acc_ff + mul_p;
            mul_a    = 28'(lz_ff);
            mul_b    = 28'(bz_ff);
            state_in = ST_D3;
         end
         ST_D3: begin
            if (rnd_dot > 56'sd32768) begin
               cos_in = 17'sd32768;
            end else if (rnd_dot < -56'sd32768) begin
               cos_in = -17'sd32768;
            end else begin
               cos_in = rnd_dot[16:0];
            end
            state_in = ST_COS;
         end
         ST_COS: begin
            mul_a    = 28'(cos_ff);
            mul_b    = 28'(cos_ff);
            state_in = ST_SIN1;
         end
         ST_SIN1: begin
            sq_req.start    = 1'b1;
            sq_req.radicand = 64'(56'sd1073741824 - mul_p);
            state_in        = ST_SIN2;
         end
         ST_SIN2: begin
            if (sq_done) begin
               sin_in   = sq_root[15:0];
               mul_a    = 28'(ly_ff);
               mul_b    = 28'(bz_ff);
               state_in = ST_C0A;
            end
         end
         ST_C0A: begin
            acc_in   = mul_p;
            mul_a    = 28'(lz_ff);
            mul_b    = 28'(by_ff);
            state_in = ST_C0B;
         end
         ST_C0B: begin
            m_in[0]    = cmag;
            cneg_in[0] = cdiff[55];
            mul_a      = 28'(lz_ff);
            mul_b      = 28'(bx_ff);
            state_in   = ST_C1A;
         end
         ST_C1A: begin
            acc_in   = mul_p;
            mul_a    = 28'(lx_ff);
            mul_b    = 28'(bz_ff);
            state_in = ST_C1B;
         end
         ST_C1B: begin
            m_in[1]    = cmag;
            cneg_in[1] = cdiff[55];
            mul_a      = 28'(lx_ff);
            mul_b      = 28'(by_ff);
            state_in   = ST_C2A;
         end
         ST_C2A: begin
            acc_in   = mul_p;
            mul_a    = 28'(ly_ff);
            mul_b    = 28'(bx_ff);
            state_in = ST_C2B;
         end
         ST_C2B: begin
            m_in[2]    = cmag;
            cneg_in[2] = cdiff[55];
            state_in   = ST_MAG;
         end
         ST_MAG: begin
            mx_in = mx3;
            if (mx3 == 32'd0) begin
               // parallel points: axis stays zero
               rv_in    = 1'b1;
               qw_in    = sat_q(-56'(cos_ff));
               lx_in    = bx_ff;
               ly_in    = by_ff;
               lz_in    = bz_ff;
               state_in = ST_OUT;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // bring the largest magnitude into [2^23, 2^24)
            if (mx_ff >= 32'h0100_0000) begin
               mx_in   = mx_ff >> 1;
               m_in[0] = m_ff[0] >> 1;
               m_in[1] = m_ff[1] >> 1;
               m_in[2] = m_ff[2] >> 1;
            end else if (mx_ff < 32'h0080_0000) begin
               mx_in   = mx_ff << 1;
               m_in[0] = m_ff[0] << 1;
               m_in[1] = m_ff[1] << 1;
               m_in[2] = m_ff[2] << 1;
            end else begin
               mul_a    = $signed({4'd0, m_ff[0][23:0]});
               mul_b    = $signed({4'd0, m_ff[0][23:0]});
               state_in = ST_SUM1;
            end
         end
         ST_SUM1: begin
            acc_in   = mul_p;
            mul_a    = $signed({4'd0, m_ff[1][23:0]});
            mul_b    = $signed({4'd0, m_ff[1][23:0]});
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            acc_in   = acc_ff + mul_p;
            mul_a    = $signed({4'd0, m_ff[2][23:0]});
            mul_b    = $signed({4'd0, m_ff[2][23:0]});
            state_in = ST_SUM3;
         end
         ST_SUM3: begin
            sq_req.start    = 1'b1;
            sq_req.radicand = 64'(acc_ff + mul_p) << 12;
            state_in        = ST_AXL;
         end
         ST_AXL: begin
            if (sq_done) begin
               len_in        = sq_root;
               k_in          = 2'd0;
               div_req.start = 1'b1;
               div_req.num   = (48'(m_ff[0][23:0]) << 21) + 48'(sq_root[31:1]);
               div_req.den   = sq_root;
               state_in      = ST_AX;
            end
         end
         ST_AX: begin
            if (div_done) begin
               ax_in      = cneg_ff[0] ? 19'(-dq) : 19'(dq);
               m_in[0]    = m_ff[1];
               m_in[1]    = m_ff[2];
               cneg_in    = {1'b0, cneg_ff[2:1]};
               state_in   = ST_AXM;
            end
         end
         ST_AXM: begin
            mul_a    = $signed({12'd0, sin_ff});
            mul_b    = 28'(ax_ff);
            state_in = ST_AXQ;
         end
         ST_AXQ: begin
            qv_in[0] = qv_ff[1];
            qv_in[1] = qv_ff[2];
            qv_in[2] = sat_q(rnd_q(mul_p));
            if (k_ff == 2'd2) begin
               rv_in    = 1'b1;
               qw_in    = sat_q(-56'(cos_ff));
               lx_in    = bx_ff;
               ly_in    = by_ff;
               lz_in    = bz_ff;
               state_in = ST_OUT;
            end else begin
               k_in          = k_ff + 2'd1;
               div_req.start = 1'b1;
               div_req.num   = (48'(m_ff[0][23:0]) << 21) + 48'(len_ff[31:1]);
               div_req.den   = len_ff;
               state_in      = ST_AX;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      radius_in = radius_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RADIUS: radius_in = csr_wdata;
            REG_THRESH: thresh_in = csr_wdata;
            default:    radius_in = radius_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         radius_ff <= RADIUS_RESET;
         thresh_ff <= THRESH_RESET;
         stw_ff    <= '0;
         sth_ff    <= '0;
         lx_ff     <= '0;
         ly_ff     <= '0;
         lz_ff     <= 16'sh7fff;
      end else begin
         state_ff  <= state_in;
         radius_ff <= radius_in;
         thresh_ff <= thresh_in;
         stw_ff    <= stw_in;
         sth_ff    <= sth_in;
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
         lz_ff     <= lz_in;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      bz_ff     <= bz_in;
      move_ff   <= move_in;
      inside_ff <= inside_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      base_ff   <= base_in;
      s_ff      <= s_in;
      br_ff     <= br_in;
      len_ff    <= len_in;
      acc_ff    <= acc_in;
      cos_ff    <= cos_in;
      sin_ff    <= sin_in;
      m_ff      <= m_in;
      cneg_ff   <= cneg_in;
      mx_ff     <= mx_in;
      ax_ff     <= ax_in;
      k_ff      <= k_in;
      hnd_ff    <= hnd_in;
      rv_ff     <= rv_in;
      verr_ff   <= verr_in;
      qw_ff     <= qw_in;
      qv_ff     <= qv_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {6'd0, verr_ff, qv_ff[2], qv_ff[1], qv_ff[0], qw_ff, hnd_ff};
   assign rsp_tuser  = rv_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides open together");

   a_rot_handled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata[0])
      else $error("rotation on an unhandled event");

   a_unhandled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[71:1] == 71'd0 && !rsp_tuser[0]))
      else $error("unhandled event with nonzero result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a second transaction while busy");

endmodule
